[rtl/slfe_pkg.sv]
// Shared types and constants for the sync and length frame extractor.
`default_nettype none
package slfe_pkg;

  localparam logic [7:0]  SYNC_A     = 8'h16;
  localparam logic [7:0]  SYNC_B     = 8'h75;
  localparam logic [7:0]  VERSION_OK = 8'h01;
  localparam int          HDR_LEN    = 10;
  localparam logic [3:0]  HDR_LAST   = 4'(HDR_LEN - 1);
  localparam logic [3:0]  HDR_FIRST_RX = 4'd3;  // first header byte taken from the link
  localparam logic [16:0] MAX_RESET  = 17'd65545;

  // output word source
  localparam logic [1:0] SEL_DROP    = 2'd0;
  localparam logic [1:0] SEL_HEADER  = 2'd1;
  localparam logic [1:0] SEL_PAYLOAD = 2'd2;

  typedef struct packed {
    logic       out_load;
    logic [1:0] out_sel;
    logic       hdr_wr;
    logic [3:0] idx;
    logic       pay_load;
    logic       pay_dec;
  } slfe_cmd_t;

  typedef struct packed {
    logic is_sync_a;
    logic is_sync_b;
    logic is_version;
    logic too_long;
    logic pay_zero;
    logic pay_one;
    logic out_free;
  } slfe_sts_t;

endpackage
`default_nettype wire

[rtl/slfe_datapath.sv]
// Datapath: header store, payload counter, length check and output register.
`default_nettype none
module slfe_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [16:0]       cfg_wr_data,
  input  wire logic [7:0]        rx_byte,
  input  wire slfe_pkg::slfe_cmd_t cmd,
  output slfe_pkg::slfe_sts_t    sts,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast,
  output logic [1:0]             out_tuser
);

  logic [16:0] max_r;
  logic [7:0]  hdr_r [3:9];
  logic [15:0] pay_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_first_r, out_last_r, out_drop_r;

  logic [15:0] len;
  logic [7:0]  hdr_byte;
  logic        out_byte_nxt_first, out_byte_nxt_last;
  logic [7:0]  out_byte_nxt;
  logic        out_drop_nxt;

  // byte 9 is the byte arriving now
  assign len = {hdr_r[8], rx_byte};

  always_comb begin
    unique case (cmd.idx)
      4'd0:    hdr_byte = slfe_pkg::SYNC_A;
      4'd1:    hdr_byte = slfe_pkg::SYNC_B;
      4'd2:    hdr_byte = slfe_pkg::VERSION_OK;
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: hdr_byte = hdr_r[cmd.idx];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    out_byte_nxt       = 8'd0;
    out_byte_nxt_first = 1'b0;
    out_byte_nxt_last  = 1'b0;
    out_drop_nxt       = 1'b0;
    unique case (cmd.out_sel)
      slfe_pkg::SEL_DROP: out_drop_nxt = 1'b1;
      slfe_pkg::SEL_HEADER: begin
        out_byte_nxt       = hdr_byte;
        out_byte_nxt_first = (cmd.idx == 4'd0);
        out_byte_nxt_last  = (cmd.idx == slfe_pkg::HDR_LAST) && (pay_r == 16'd0);
      end
      slfe_pkg::SEL_PAYLOAD: begin
        out_byte_nxt      = rx_byte;
        out_byte_nxt_last = (pay_r == 16'd1);
      end
      default: out_drop_nxt = 1'b0;
    endcase
  end

  assign sts.is_sync_a  = (rx_byte == slfe_pkg::SYNC_A);
  assign sts.is_sync_b  = (rx_byte == slfe_pkg::SYNC_B);
  assign sts.is_version = (rx_byte == slfe_pkg::VERSION_OK);
  assign sts.too_long   = (({1'b0, len} + 17'(slfe_pkg::HDR_LEN)) > max_r);
  assign sts.pay_zero   = (pay_r == 16'd0);
  assign sts.pay_one    = (pay_r == 16'd1);
  assign sts.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= slfe_pkg::MAX_RESET;
      out_valid_r <= 1'b0;
      pay_r       <= 16'd0;
    end else begin
      if (cfg_wr_en) max_r <= cfg_wr_data;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cmd.pay_load) pay_r <= len;
      else if (cmd.pay_dec) pay_r <= pay_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_wr && cmd.idx >= slfe_pkg::HDR_FIRST_RX && cmd.idx <= slfe_pkg::HDR_LAST)
      hdr_r[cmd.idx] <= rx_byte;
    if (cmd.out_load) begin
      out_byte_r  <= out_byte_nxt;
      out_first_r <= out_byte_nxt_first;
      out_last_r  <= out_byte_nxt_last;
      out_drop_r  <= out_drop_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_drop_r, out_first_r};

endmodule
`default_nettype wire

[rtl/slfe_ctrl.sv]
// Controller: sync hunt, header count, header drain and payload sequencing.
`default_nettype none
module slfe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire slfe_pkg::slfe_sts_t sts,
  output slfe_pkg::slfe_cmd_t     cmd
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_SAW_A   = 3'd1;
  localparam logic [2:0] ST_SAW_B   = 3'd2;
  localparam logic [2:0] ST_HEADER  = 3'd3;
  localparam logic [2:0] ST_DRAIN   = 3'd4;
  localparam logic [2:0] ST_PAYLOAD = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       acc;
  logic [2:0] hunt_nxt;

  assign in_tready = (state_r != ST_DRAIN) && sts.out_free;
  assign acc       = in_tvalid && in_tready;
  assign hunt_nxt  = sts.is_sync_a ? ST_SAW_A : ST_HUNT;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.idx      = idx_r;
    cmd.out_sel  = slfe_pkg::SEL_DROP;
    unique case (state_r)
      ST_SAW_A: if (acc) state_nxt = sts.is_sync_b ? ST_SAW_B : hunt_nxt;
      ST_SAW_B: begin
        if (acc) begin
          if (sts.is_version) begin
            state_nxt = ST_HEADER;
            idx_nxt   = slfe_pkg::HDR_FIRST_RX;
          end else begin
            state_nxt = hunt_nxt;
          end
        end
      end
      ST_HEADER: begin
        if (acc) begin
          cmd.hdr_wr = 1'b1;
          if (idx_r == slfe_pkg::HDR_LAST) begin
            idx_nxt = 4'd0;
            if (sts.too_long) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = slfe_pkg::SEL_DROP;
              state_nxt    = ST_HUNT;
            end else begin
              cmd.pay_load = 1'b1;
              state_nxt    = ST_DRAIN;
            end
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      ST_DRAIN: begin
        // header words leave one per free output slot
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = slfe_pkg::SEL_HEADER;
          if (idx_r == slfe_pkg::HDR_LAST) begin
            idx_nxt   = 4'd0;
            state_nxt = sts.pay_zero ? ST_HUNT : ST_PAYLOAD;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      ST_PAYLOAD: begin
        if (acc) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = slfe_pkg::SEL_PAYLOAD;
          cmd.pay_dec  = 1'b1;
          if (sts.pay_one) state_nxt = ST_HUNT;
        end
      end
      default: if (acc) state_nxt = hunt_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      idx_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/sync_length_frame_extractor_top.sv]
// Top level of the sync and length frame extractor.
`default_nettype none
// Takes received link bytes one word at a time, hunts for the start sequence
// 0x16 0x75 0x01, collects the 10-byte header and reads the big-endian payload
// length from header bytes 8 and 9. A frame whose length plus 10 exceeds
// cfg_wr_data's last written value (reset 65545) yields one word with the drop
// flag set and zero data; otherwise the header and then the payload stream out
// with first and last marks. Hunt, header and payload bytes are accepted only
// while the output register is free. After the last header byte the input is
// held while the controller drains the stored header through the single output
// register; no clearing pass is used.
module sync_length_frame_extractor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data,   // max_frame_bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,     // frame_byte
  output logic             out_tlast,
  output logic [1:0]       out_tuser      // [0] first, [1] dropped
);

  slfe_pkg::slfe_cmd_t cmd;
  slfe_pkg::slfe_sts_t sts;

  slfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slfe_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx_byte     (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
`default_nettype wire
